// File: sv/psrd_pkg.sv
// psrd_pkg: shared constants, register map and limit helpers for the
// pixel shuffle residual dequant block; no dependencies
package psrd_pkg;

  localparam int MAX_TILE  = 128;
  localparam int MAX_SCALE = 4;

  // widths of the configuration fields and counters
  localparam int TILE_W  = 8;
  localparam int SCALE_W = 3;
  localparam int ZP_W    = 8;
  localparam int GAIN_W  = 24;
  localparam int COL_W   = $clog2(MAX_TILE);
  localparam int SUB_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int COORD_W = 9;

  // channel arithmetic: 8-bit base, int8 code, Q8.16 gain
  localparam int PIX_W     = 8;
  localparam int FRAC_BITS = 16;
  localparam int DIFF_W    = PIX_W + 1;
  localparam int PROD_W    = DIFF_W + GAIN_W + 1;
  localparam int SUM_W     = PROD_W + 1;

  // register map, one 32-bit word per register
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_TILE_SIZE   = 2'd0;
  localparam logic [1:0] REG_SCALE       = 2'd1;
  localparam logic [1:0] REG_ZERO_POINT  = 2'd2;
  localparam logic [1:0] REG_DETAIL_GAIN = 2'd3;

  localparam logic [TILE_W-1:0]  TILE_RST  = TILE_W'(64);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(4);
  localparam logic [ZP_W-1:0]    ZP_RST    = '0;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(24'hFF0000);

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [TILE_W-1:0] tile_limit(input logic [TILE_W-1:0] v);
    logic [TILE_W-1:0] res;
    if (v == '0) res = TILE_W'(1);
    else if (v > TILE_W'(MAX_TILE)) res = TILE_W'(MAX_TILE);
    else res = v;
    return res;
  endfunction

  function automatic logic [SCALE_W-1:0] scale_limit(input logic [SCALE_W-1:0] v);
    logic [SCALE_W-1:0] res;
    if (v == '0) res = SCALE_W'(1);
    else if (v > SCALE_W'(MAX_SCALE)) res = SCALE_W'(MAX_SCALE);
    else res = v;
    return res;
  endfunction

endpackage

// File: sv/psrd_channel.sv
// psrd_channel: dequantizes one color channel, base*2^16 + (code - zp)*gain,
// then clamps to 0..255 with round half up; uses psrd_pkg
module psrd_channel import psrd_pkg::*; (
  input  logic [PIX_W-1:0]  base,
  input  logic [PIX_W-1:0]  code,
  input  logic [ZP_W-1:0]   zero_point,
  input  logic [GAIN_W-1:0] gain,
  output logic [PIX_W-1:0]  value
);

  localparam logic signed [SUM_W-1:0] TOP_FIXED  = SUM_W'(255) <<< FRAC_BITS;
  localparam logic signed [SUM_W-1:0] HALF_FIXED = SUM_W'(1) <<< (FRAC_BITS - 1);

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  rounded;

  assign diff    = {code[PIX_W-1], code} - {zero_point[ZP_W-1], zero_point};
  assign prod    = diff * $signed({1'b0, gain});
  assign sum     = $signed({prod[PROD_W-1], prod})
                 + $signed({(SUM_W-PIX_W-FRAC_BITS)'(0), base, FRAC_BITS'(0)});
  assign rounded = sum + HALF_FIXED;

  always_comb begin
    if (sum[SUM_W-1] || sum == '0) begin
      value = '0;
    end else if (sum >= TOP_FIXED) begin
      value = '1;
    end else begin
      value = rounded[FRAC_BITS +: PIX_W];
    end
  end

endmodule

// File: sv/pixel_shuffle_residual_dequant.sv
// pixel_shuffle_residual_dequant: two-register pipeline, input register then
// result register; out_tvalid rises when the result register loads, which
// it does only while it is empty or its output is being taken.
// throughput one pixel per cycle while out_tready stays high; the only limit
// is the combinational 9x24 multiply per channel between the two registers.
// rst_n (synchronous) clears both valid bits and the tile counters and
// returns the registers to tile 64, scale 4, zero point 0, gain 255.0.
// uses psrd_pkg and psrd_channel
module pixel_shuffle_residual_dequant import psrd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // stream in
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,   // base_red, base_green, base_blue,
                                        // detail_red, detail_green, detail_blue
  // stream out
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,  // red, green, blue, out_x[32:24],
                                        // out_y[41:33], zero fill
  output logic              out_tlast,  // tile_end
  // register port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // configuration
  logic [TILE_W-1:0]  tile_size_r;
  logic [SCALE_W-1:0] scale_r;
  logic [ZP_W-1:0]    zero_point_r;
  logic [GAIN_W-1:0]  detail_gain_r;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_idx)
      REG_TILE_SIZE:   cfg_prdata = DATA_W'(tile_size_r);
      REG_SCALE:       cfg_prdata = DATA_W'(scale_r);
      REG_ZERO_POINT:  cfg_prdata = DATA_W'(zero_point_r);
      REG_DETAIL_GAIN: cfg_prdata = DATA_W'(detail_gain_r);
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_size_r   <= TILE_RST;
      scale_r       <= SCALE_RST;
      zero_point_r  <= ZP_RST;
      detail_gain_r <= GAIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TILE_SIZE:   tile_size_r   <= cfg_pwdata[TILE_W-1:0];
        REG_SCALE:       scale_r       <= cfg_pwdata[SCALE_W-1:0];
        REG_ZERO_POINT:  zero_point_r  <= cfg_pwdata[ZP_W-1:0];
        REG_DETAIL_GAIN: detail_gain_r <= cfg_pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and pipeline control
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_ld, in_fire;

  assign out_ld     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || out_ld;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) s1_valid_nxt = 1'b1;
    else if (out_ld) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_ld) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  // tile counters, sub_col fastest
  logic [COL_W-1:0]   low_col_r, low_row_r, low_col_nxt, low_row_nxt;
  logic [SUB_W-1:0]   sub_col_r, sub_row_r, sub_col_nxt, sub_row_nxt;
  logic [TILE_W-1:0]  ts;
  logic [SCALE_W-1:0] sc;
  logic               last_sc, last_sr, last_lc, last_lr, last_all;
  logic [COORD_W-1:0] x_cur, y_cur;

  assign ts = tile_limit(tile_size_r);
  assign sc = scale_limit(scale_r);

  // a counter at or past a reduced limit counts as last and wraps
  assign last_sc  = (SCALE_W+1)'(sub_col_r) + (SCALE_W+1)'(1) >= (SCALE_W+1)'(sc);
  assign last_sr  = (SCALE_W+1)'(sub_row_r) + (SCALE_W+1)'(1) >= (SCALE_W+1)'(sc);
  assign last_lc  = (TILE_W+1)'(low_col_r) + (TILE_W+1)'(1) >= (TILE_W+1)'(ts);
  assign last_lr  = (TILE_W+1)'(low_row_r) + (TILE_W+1)'(1) >= (TILE_W+1)'(ts);
  assign last_all = last_sc && last_sr && last_lc && last_lr;

  assign x_cur = COORD_W'(low_col_r * sc + (COL_W+SCALE_W)'(sub_col_r));
  assign y_cur = COORD_W'(low_row_r * sc + (COL_W+SCALE_W)'(sub_row_r));

  always_comb begin
    sub_col_nxt = sub_col_r;
    sub_row_nxt = sub_row_r;
    low_col_nxt = low_col_r;
    low_row_nxt = low_row_r;
    if (in_fire) begin
      if (!last_sc) begin
        sub_col_nxt = sub_col_r + SUB_W'(1);
      end else begin
        sub_col_nxt = '0;
        if (!last_sr) begin
          sub_row_nxt = sub_row_r + SUB_W'(1);
        end else begin
          sub_row_nxt = '0;
          if (!last_lc) begin
            low_col_nxt = low_col_r + COL_W'(1);
          end else begin
            low_col_nxt = '0;
            low_row_nxt = last_lr ? '0 : low_row_r + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sub_col_r   <= '0;
      sub_row_r   <= '0;
      low_col_r   <= '0;
      low_row_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      sub_col_r   <= sub_col_nxt;
      sub_row_r   <= sub_row_nxt;
      low_col_r   <= low_col_nxt;
      low_row_r   <= low_row_nxt;
    end
  end

  // input register
  logic [47:0]        s1_data_r;
  logic [COORD_W-1:0] s1_x_r, s1_y_r;
  logic               s1_last_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_tdata;
      s1_x_r    <= x_cur;
      s1_y_r    <= y_cur;
      s1_last_r <= last_all;
    end
  end

  // dequant between the registers
  logic [PIX_W-1:0] red, green, blue;

  psrd_channel u_red (
    .base(s1_data_r[7:0]), .code(s1_data_r[31:24]),
    .zero_point(zero_point_r), .gain(detail_gain_r), .value(red)
  );
  psrd_channel u_green (
    .base(s1_data_r[15:8]), .code(s1_data_r[39:32]),
    .zero_point(zero_point_r), .gain(detail_gain_r), .value(green)
  );
  psrd_channel u_blue (
    .base(s1_data_r[23:16]), .code(s1_data_r[47:40]),
    .zero_point(zero_point_r), .gain(detail_gain_r), .value(blue)
  );

  // result register
  logic [47:0] out_data_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_data_r <= {6'b0, s1_y_r, s1_x_r, blue, green, red};
      out_last_r <= s1_last_r;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

`ifndef NO_ASSERTIONS
  a_tile_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && last_all |=> low_col_r == '0 && low_row_r == '0 &&
                            sub_col_r == '0 && sub_row_r == '0)
    else $error("counters not cleared after last pixel of tile");

  a_sub_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !last_sc |=> sub_col_r == $past(sub_col_r) + SUB_W'(1))
    else $error("sub column did not advance");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_ld |=> s1_valid_r)
    else $error("input register dropped a pending item");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled while input register empty");
`endif

endmodule
